/* sv/pi16alu_pkg.sv */
// ----------------------------------------------------------------------------
// pi16alu_pkg
// Shared types and operation codes for the packed 8 x int16 ALU.
// ----------------------------------------------------------------------------
package pi16alu_pkg;

  localparam int LANE_W   = 16;
  localparam int LANES    = 8;
  localparam int KIND_W   = 5;
  localparam int CNT_W    = 4;
  localparam int VEC_W    = LANE_W * LANES;
  localparam int IN_DATA_W  = 280;
  localparam int OUT_DATA_W = 128;

  // Saturation limits
  localparam logic [LANE_W-1:0] SAT_MAX = 16'h7fff;
  localparam logic [LANE_W-1:0] SAT_MIN = 16'h8000;
  localparam logic [LANE_W-1:0] ALL_ONES = 16'hffff;

  // Operation codes
  localparam logic [KIND_W-1:0] OP_ADD    = 5'd0;
  localparam logic [KIND_W-1:0] OP_SUB    = 5'd1;
  localparam logic [KIND_W-1:0] OP_MUL    = 5'd2;
  localparam logic [KIND_W-1:0] OP_AND    = 5'd3;
  localparam logic [KIND_W-1:0] OP_OR     = 5'd4;
  localparam logic [KIND_W-1:0] OP_XOR    = 5'd5;
  localparam logic [KIND_W-1:0] OP_ADDSAT = 5'd6;
  localparam logic [KIND_W-1:0] OP_SUBSAT = 5'd7;
  localparam logic [KIND_W-1:0] OP_MIN    = 5'd8;
  localparam logic [KIND_W-1:0] OP_MAX    = 5'd9;
  localparam logic [KIND_W-1:0] OP_LT     = 5'd10;
  localparam logic [KIND_W-1:0] OP_LE     = 5'd11;
  localparam logic [KIND_W-1:0] OP_EQ     = 5'd12;
  localparam logic [KIND_W-1:0] OP_NE     = 5'd13;
  localparam logic [KIND_W-1:0] OP_GT     = 5'd14;
  localparam logic [KIND_W-1:0] OP_GE     = 5'd15;
  localparam logic [KIND_W-1:0] OP_NEG    = 5'd16;
  localparam logic [KIND_W-1:0] OP_NOT    = 5'd17;
  localparam logic [KIND_W-1:0] OP_SHL    = 5'd18;
  localparam logic [KIND_W-1:0] OP_SAR    = 5'd19;
  localparam logic [KIND_W-1:0] OP_SPLAT  = 5'd20;

  // Input tdata layout, last field in the lowest bits
  typedef struct packed {
    logic [15:0] splat_scalar;
    logic [7:0]  shift_count;
    logic [63:0] b_high;
    logic [63:0] b_low;
    logic [63:0] a_high;
    logic [63:0] a_low;
  } in_item_t;

endpackage

/* sv/pi16alu_lane.sv */
// ----------------------------------------------------------------------------
// pi16alu_lane
// One signed 16-bit lane of the packed ALU, purely combinational.
// ----------------------------------------------------------------------------
module pi16alu_lane (
  input  logic [pi16alu_pkg::KIND_W-1:0] kind,
  input  logic [pi16alu_pkg::LANE_W-1:0] x,
  input  logic [pi16alu_pkg::LANE_W-1:0] y,
  input  logic [pi16alu_pkg::CNT_W-1:0]  cnt,
  input  logic [pi16alu_pkg::LANE_W-1:0] splat,
  output logic [pi16alu_pkg::LANE_W-1:0] res
);

  logic [16:0] sum_x;
  logic [16:0] dif_x;
  logic [15:0] sum_sat;
  logic [15:0] dif_sat;
  logic [15:0] prod;
  logic        lt;
  logic        eq;

  // Widened add and subtract for saturation
  assign sum_x = {x[15], x} + {y[15], y};
  assign dif_x = {x[15], x} - {y[15], y};

  // Overflow when the two top bits disagree; the top bit gives the direction
  assign sum_sat = (sum_x[16] != sum_x[15]) ?
                   (sum_x[16] ? pi16alu_pkg::SAT_MIN : pi16alu_pkg::SAT_MAX) :
                   sum_x[15:0];
  assign dif_sat = (dif_x[16] != dif_x[15]) ?
                   (dif_x[16] ? pi16alu_pkg::SAT_MIN : pi16alu_pkg::SAT_MAX) :
                   dif_x[15:0];

  // Low half of the product is the same signed or unsigned
  assign prod = x * y;

  assign lt = $signed(x) < $signed(y);
  assign eq = (x == y);

  // Result select
  always_comb begin
    case (kind)
      pi16alu_pkg::OP_ADD:    res = x + y;
      pi16alu_pkg::OP_SUB:    res = x - y;
      pi16alu_pkg::OP_MUL:    res = prod;
      pi16alu_pkg::OP_AND:    res = x & y;
      pi16alu_pkg::OP_OR:     res = x | y;
      pi16alu_pkg::OP_XOR:    res = x ^ y;
      pi16alu_pkg::OP_ADDSAT: res = sum_sat;
      pi16alu_pkg::OP_SUBSAT: res = dif_sat;
      pi16alu_pkg::OP_MIN:    res = lt ? x : y;
      pi16alu_pkg::OP_MAX:    res = (!lt && !eq) ? x : y;
      pi16alu_pkg::OP_LT:     res = lt ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_LE:     res = (lt || eq) ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_EQ:     res = eq ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_NE:     res = eq ? '0 : pi16alu_pkg::ALL_ONES;
      pi16alu_pkg::OP_GT:     res = (!lt && !eq) ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_GE:     res = lt ? '0 : pi16alu_pkg::ALL_ONES;
      pi16alu_pkg::OP_NEG:    res = 16'd0 - x;
      pi16alu_pkg::OP_NOT:    res = ~x;
      pi16alu_pkg::OP_SHL:    res = x << cnt;
      pi16alu_pkg::OP_SAR:    res = 16'($signed(x) >>> cnt);
      pi16alu_pkg::OP_SPLAT:  res = splat;
      default:                res = '0;
    endcase
  end

endmodule

/* sv/packed_int16x8_simd_alu.sv */
// ----------------------------------------------------------------------------
// packed_int16x8_simd_alu
// Packed ALU over eight signed 16-bit lanes with registered input and result.
// ----------------------------------------------------------------------------
//  channel  | signals                    | content
//  ---------+----------------------------+-----------------------------------
//  s_       | tvalid tready tdata tuser  | operands, shift, scalar; op code
//  m_       | tvalid tready tdata        | 128-bit result
//
// Two register stages: an item is captured in the input register, the eight
// lane ALUs work on it, and the result lands in the output register. One
// item is taken every cycle while m_ does not stall. A stall on m_ holds the
// result register and backs up through the input register to s_tready.
// Reset clears both valid flags only.
// ----------------------------------------------------------------------------
module packed_int16x8_simd_alu (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // a_low, a_high, b_low, b_high, shift_count, splat_scalar
  input  logic [pi16alu_pkg::IN_DATA_W-1:0]    s_tdata,
  // kind
  input  logic [pi16alu_pkg::KIND_W-1:0]       s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // result_low, result_high
  output logic [pi16alu_pkg::OUT_DATA_W-1:0]   m_tdata
);

  logic                                in_v;
  logic [pi16alu_pkg::KIND_W-1:0]      in_kind;
  pi16alu_pkg::in_item_t               in_item;
  logic                                out_v;
  logic [pi16alu_pkg::VEC_W-1:0]       out_data;
  logic                                out_en;
  logic                                in_en;
  logic [pi16alu_pkg::VEC_W-1:0]       vec_a;
  logic [pi16alu_pkg::VEC_W-1:0]       vec_b;
  logic [pi16alu_pkg::VEC_W-1:0]       res_next;

  // Stage enables
  assign out_en   = !out_v || m_tready;
  assign in_en    = !in_v || out_en;
  assign s_tready = in_en;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (in_en) begin
      in_v <= s_tvalid;
    end
    if (in_en && s_tvalid) begin
      in_kind <= s_tuser;
      in_item <= pi16alu_pkg::in_item_t'(s_tdata);
    end
  end

  assign vec_a = {in_item.a_high, in_item.a_low};
  assign vec_b = {in_item.b_high, in_item.b_low};

  // Lane ALUs
  for (genvar i = 0; i < pi16alu_pkg::LANES; i++) begin : g_lane
    pi16alu_lane u_lane (
      .kind  (in_kind),
      .x     (vec_a[i*pi16alu_pkg::LANE_W +: pi16alu_pkg::LANE_W]),
      .y     (vec_b[i*pi16alu_pkg::LANE_W +: pi16alu_pkg::LANE_W]),
      .cnt   (in_item.shift_count[pi16alu_pkg::CNT_W-1:0]),
      .splat (in_item.splat_scalar),
      .res   (res_next[i*pi16alu_pkg::LANE_W +: pi16alu_pkg::LANE_W])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_en) begin
      out_v <= in_v;
    end
    if (out_en && in_v) begin
      out_data <= res_next;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_data;

endmodule

/* sim/tb_packed_int16x8_simd_alu.sv */
// ----------------------------------------------------------------------------
// tb_packed_int16x8_simd_alu
// Self-checking testbench for the packed 8 x int16 ALU.
// Every accepted input item is run through a lane-by-lane predictor. The
// predicted 128-bit vector is queued and compared with each result item as
// it leaves the block. A short directed pass covers every operation, the
// field extremes and the corner cases. It is followed by a long random pass.
// The sender idles in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_packed_int16x8_simd_alu;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  // Codes outside the defined set give an all-zero result
  localparam logic [pi16alu_pkg::KIND_W-1:0] OP_UNUSED_FIRST = 5'd21;
  localparam logic [pi16alu_pkg::KIND_W-1:0] OP_UNUSED_LAST  = 5'd31;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [pi16alu_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [pi16alu_pkg::KIND_W-1:0]     s_tuser = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [pi16alu_pkg::OUT_DATA_W-1:0] m_tdata;

  // Predicted result vectors, oldest first
  logic [pi16alu_pkg::VEC_W-1:0] predicted_vectors[$];

  int   error_count   = 0;
  int   items_sent    = 0;
  int   results_seen  = 0;
  int   idle_cycles   = 0;
  int   burst_left    = 0;
  bit [31:0] ops_seen = '0;

  packed_int16x8_simd_alu DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // One lane of the ALU
  function automatic logic [pi16alu_pkg::LANE_W-1:0] lane_alu(
    input logic [pi16alu_pkg::KIND_W-1:0] op,
    input logic [pi16alu_pkg::LANE_W-1:0] x,
    input logic [pi16alu_pkg::LANE_W-1:0] y,
    input logic [pi16alu_pkg::CNT_W-1:0]  cnt,
    input logic [pi16alu_pkg::LANE_W-1:0] sp);
    logic signed [pi16alu_pkg::LANE_W-1:0] sx;
    logic signed [pi16alu_pkg::LANE_W-1:0] sy;
    logic signed [pi16alu_pkg::LANE_W:0]   wide;
    logic [2*pi16alu_pkg::LANE_W-1:0]      prod;
    logic signed [pi16alu_pkg::LANE_W-1:0] shifted;
    sx = x;
    sy = y;
    case (op)
      pi16alu_pkg::OP_ADD: return x + y;
      pi16alu_pkg::OP_SUB: return x - y;
      pi16alu_pkg::OP_MUL: begin
        prod = x * y;
        return prod[pi16alu_pkg::LANE_W-1:0];
      end
      pi16alu_pkg::OP_AND: return x & y;
      pi16alu_pkg::OP_OR:  return x | y;
      pi16alu_pkg::OP_XOR: return x ^ y;
      pi16alu_pkg::OP_ADDSAT, pi16alu_pkg::OP_SUBSAT: begin
        wide = (op == pi16alu_pkg::OP_ADDSAT) ? sx + sy : sx - sy;
        if (wide > 17'sd32767) return pi16alu_pkg::SAT_MAX;
        if (wide < -17'sd32768) return pi16alu_pkg::SAT_MIN;
        return wide[pi16alu_pkg::LANE_W-1:0];
      end
      pi16alu_pkg::OP_MIN: return (sx < sy) ? x : y;
      pi16alu_pkg::OP_MAX: return (sx > sy) ? x : y;
      pi16alu_pkg::OP_LT:  return (sx <  sy) ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_LE:  return (sx <= sy) ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_EQ:  return (x  == y)  ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_NE:  return (x  != y)  ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_GT:  return (sx >  sy) ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_GE:  return (sx >= sy) ? pi16alu_pkg::ALL_ONES : '0;
      pi16alu_pkg::OP_NEG: return -x;
      pi16alu_pkg::OP_NOT: return ~x;
      pi16alu_pkg::OP_SHL: return x << cnt;
      pi16alu_pkg::OP_SAR: begin
        shifted = sx >>> cnt;
        return shifted;
      end
      pi16alu_pkg::OP_SPLAT: return sp;
      default: return '0;
    endcase
  endfunction

  // Whole result vector for one input item
  function automatic logic [pi16alu_pkg::VEC_W-1:0] alu_vector(
    input logic [pi16alu_pkg::KIND_W-1:0] op,
    input pi16alu_pkg::in_item_t          it);
    logic [pi16alu_pkg::VEC_W-1:0] va;
    logic [pi16alu_pkg::VEC_W-1:0] vb;
    logic [pi16alu_pkg::VEC_W-1:0] vr;
    va = {it.a_high, it.a_low};
    vb = {it.b_high, it.b_low};
    for (int i = 0; i < pi16alu_pkg::LANES; i++)
      vr[pi16alu_pkg::LANE_W*i +: pi16alu_pkg::LANE_W] =
        lane_alu(op, va[pi16alu_pkg::LANE_W*i +: pi16alu_pkg::LANE_W],
                 vb[pi16alu_pkg::LANE_W*i +: pi16alu_pkg::LANE_W],
                 it.shift_count[pi16alu_pkg::CNT_W-1:0], it.splat_scalar);
    return vr;
  endfunction

  // --------------------------------------------------------------------------
  // Monitors: predict on input acceptance, compare on output acceptance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predicted_vectors.push_back(alu_vector(s_tuser, pi16alu_pkg::in_item_t'(s_tdata)));
      ops_seen[s_tuser] = 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [pi16alu_pkg::VEC_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (predicted_vectors.size() == 0) begin
        $error("result item with nothing predicted: %h", m_tdata);
        error_count++;
      end else begin
        want = predicted_vectors.pop_front();
        if (m_tdata[63:0] !== want[63:0]) begin
          $error("result_low: expected %h, actual %h", want[63:0], m_tdata[63:0]);
          error_count++;
        end
        if (m_tdata[127:64] !== want[127:64]) begin
          $error("result_high: expected %h, actual %h", want[127:64], m_tdata[127:64]);
          error_count++;
        end
      end
    end
  end

  // Receiver: ready pattern switches between modes every so often
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((rx_tick % 7) < 3);
    endcase
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one item; idles between bursts of random length
  task automatic send_item(input logic [pi16alu_pkg::KIND_W-1:0] op,
                           input pi16alu_pkg::in_item_t          it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 60);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  function automatic pi16alu_pkg::in_item_t pack_operands(
    input logic [pi16alu_pkg::VEC_W-1:0] va,
    input logic [pi16alu_pkg::VEC_W-1:0] vb,
    input logic [7:0]                    cnt,
    input logic [15:0]                   sp);
    pi16alu_pkg::in_item_t it;
    it.a_low        = va[63:0];
    it.a_high       = va[127:64];
    it.b_low        = vb[63:0];
    it.b_high       = vb[127:64];
    it.shift_count  = cnt;
    it.splat_scalar = sp;
    return it;
  endfunction

  // Lane value biased towards the interesting corners
  function automatic logic [pi16alu_pkg::LANE_W-1:0] pick_lane();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return pi16alu_pkg::SAT_MAX;
      2: return pi16alu_pkg::SAT_MIN;
      3: return pi16alu_pkg::ALL_ONES;
      4: return 16'h0001;
      default: return 16'($urandom());
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Each defined operation once on a vector of corner lanes
  task automatic test_every_operation();
    logic [pi16alu_pkg::VEC_W-1:0] va;
    logic [pi16alu_pkg::VEC_W-1:0] vb;
    va = {16'h1234, 16'h7fff, 16'h8000, 16'h0001, 16'h0000, 16'hffff, 16'h8000, 16'h7fff};
    vb = {16'h1234, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h0001};
    for (int op = pi16alu_pkg::OP_ADD; op <= pi16alu_pkg::OP_SPLAT; op++)
      send_item(op[pi16alu_pkg::KIND_W-1:0], pack_operands(va, vb, 8'h13, 16'h8000));
  endtask

  // Unknown codes, shift count wrap, all-ones and all-zero fields
  task automatic test_special_cases();
    logic [pi16alu_pkg::VEC_W-1:0] ones;
    logic [pi16alu_pkg::VEC_W-1:0] mins;
    ones = '1;
    mins = {pi16alu_pkg::LANES{pi16alu_pkg::SAT_MIN}};
    send_item(OP_UNUSED_FIRST, pack_operands(ones, ones, 8'hff, 16'hffff));
    send_item(OP_UNUSED_LAST, pack_operands(ones, ones, 8'hff, 16'hffff));
    // count of 16 behaves as 0
    send_item(pi16alu_pkg::OP_SHL, pack_operands(ones, '0, 8'h10, 16'h0000));
    send_item(pi16alu_pkg::OP_SAR, pack_operands(mins, ones, 8'hff, 16'h0000));
    send_item(pi16alu_pkg::OP_SPLAT, pack_operands(ones, ones, 8'h00, 16'h7fff));
    send_item(pi16alu_pkg::OP_ADD, pack_operands(ones, ones, 8'h00, 16'h0000));
    send_item(pi16alu_pkg::OP_SUB, pack_operands('0, ones, 8'h00, 16'h0000));
  endtask

  // Random operations on corner-biased lanes, with equal lanes now and then
  task automatic test_random_mix();
    logic [pi16alu_pkg::VEC_W-1:0]  va;
    logic [pi16alu_pkg::VEC_W-1:0]  vb;
    logic [pi16alu_pkg::KIND_W-1:0] op;
    int                             share;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      share = $urandom_range(0, 99);
      for (int i = 0; i < pi16alu_pkg::LANES; i++) begin
        va[pi16alu_pkg::LANE_W*i +: pi16alu_pkg::LANE_W] = pick_lane();
        vb[pi16alu_pkg::LANE_W*i +: pi16alu_pkg::LANE_W] =
          (share < 20 && $urandom_range(0, 1)) ?
          va[pi16alu_pkg::LANE_W*i +: pi16alu_pkg::LANE_W] : pick_lane();
      end
      op = ($urandom_range(0, 19) == 0) ?
           5'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST)) :
           5'($urandom_range(pi16alu_pkg::OP_ADD, pi16alu_pkg::OP_SPLAT));
      send_item(op, pack_operands(va, vb, 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535))));
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_every_operation();
    test_special_cases();
    test_random_mix();
    s_tvalid <= 1'b0;
    while (predicted_vectors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items over %0d distinct operation codes; checked %0d results.",
             items_sent, $countones(ops_seen), results_seen);
    $display("Mismatches and stray results: %0d", error_count);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* packed_int16x8_simd_alu.f */
sv/pi16alu_pkg.sv
sv/pi16alu_lane.sv
sv/packed_int16x8_simd_alu.sv
sim/tb_packed_int16x8_simd_alu.sv
